### hw/rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants of the k-means codebook trainer: component
// format, lane control bundle, operation codes, register indexes and states.
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int DIMS      = 4;
    localparam int COMP_BITS = 16;
    localparam int ND_W      = $clog2(DIMS + 1);
    localparam int SQ_W      = 2 * COMP_BITS;
    localparam int SUM_W     = SQ_W + $clog2(DIMS);

    typedef logic [COMP_BITS-1:0] t_comp;
    typedef logic [SQ_W-1:0]      t_sq;

    typedef struct packed {
        logic sq_en;
        logic acc_clr;
        logic acc_en;
        logic div_clr;
        logic div_step;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        OP_LOAD_VEC  = 3'd0,
        OP_LOAD_CW   = 3'd1,
        OP_RUN       = 3'd2,
        OP_READ_CW   = 3'd3,
        OP_READ_ASG  = 3'd4
    } t_op;

    localparam logic [2:0] CFG_DIMS    = 3'd0;
    localparam logic [2:0] CFG_NCW     = 3'd1;
    localparam logic [2:0] CFG_NVEC    = 3'd2;
    localparam logic [2:0] CFG_MAXIT   = 3'd3;
    localparam logic [2:0] CFG_THRESH  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDASG,
        ST_A_RD,
        ST_A_ISSUE,
        ST_A_DRAIN,
        ST_A_WR,
        ST_U_SCAN,
        ST_U_DRAIN,
        ST_U_LOAD,
        ST_U_DIV,
        ST_U_WB,
        ST_ITER
    } t_state;

endpackage

### hw/rtl/kmeans_codebook_trainer.sv
// ----------------------------------------------------------------------------
// kmeans_codebook_trainer
// Generalised Lloyd codebook training on unsigned Q0.16 vectors with
// component lanes, a merging stage and on-chip vector, codebook and
// assignment stores.
// ----------------------------------------------------------------------------
// Load and read items are served from the idle state; a read of an assignment
// passes through ST_RDASG for the registered store read. A run item holds the
// input until training ends. Each iteration has an assignment pass, a search of
// one codeword per cycle through the lanes and merge stage, and an update pass,
// a member scan of one vector per cycle and a bit-serial mean division
// (ACC_W = 16 + clog2(vectors+1) steps). ST_ITER closes each iteration. No
// clearing pass is needed.
module kmeans_codebook_trainer #(
    parameter int MAX_VECTORS   = 1024,
    parameter int MAX_CODEWORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [9:0]  i_index,
    input  logic [15:0] i_comp0,
    input  logic [15:0] i_comp1,
    input  logic [15:0] i_comp2,
    input  logic [15:0] i_comp3,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_comp0,
    output logic [15:0] o_out_comp1,
    output logic [15:0] o_out_comp2,
    output logic [15:0] o_out_comp3,
    output logic [3:0]  o_cluster_of_vector,
    output logic [9:0]  o_iterations_done,
    output logic        o_converged
);
    import kct_pkg::*;

    localparam int VA_W  = $clog2(MAX_VECTORS);
    localparam int VC_W  = $clog2(MAX_VECTORS + 1);
    localparam int CA_W  = $clog2(MAX_CODEWORDS);
    localparam int CC_W  = $clog2(MAX_CODEWORDS + 1);
    localparam int ACC_W = COMP_BITS + VC_W;
    localparam int DS_W  = $clog2(ACC_W);

    // configuration
    logic [2:0]  r_cfg_nd;
    logic [4:0]  r_cfg_nc;
    logic [10:0] r_cfg_nv;
    logic [9:0]  r_cfg_maxit;
    t_comp       r_cfg_thr;

    t_state r_state, n_state;

    logic [ND_W-1:0] r_nd, n_nd;
    logic [CC_W-1:0] r_nc, n_nc;
    logic [VC_W-1:0] r_nv, n_nv;

    logic [VC_W-1:0] r_vi, r_vj, r_cnt;
    logic [CA_W-1:0] r_cj, r_ci, r_p1_j;
    logic [DS_W-1:0] r_dstep;
    logic            r_sq_pend, r_acc_pend;
    logic            r_bad;
    logic [9:0]      r_iter;
    logic            r_conv;
    logic            r_rd_ok;
    logic            r_out_valid;
    t_comp           r_out_comp [DIMS];
    logic [3:0]      r_out_cluster;

    // stores
    t_comp                r_vmem [MAX_VECTORS][DIMS];
    logic [CA_W-1:0]      r_amem [MAX_VECTORS];
    t_comp                r_cb   [MAX_CODEWORDS][DIMS];
    t_comp                r_vmem_q [DIMS];
    logic [CA_W-1:0]      r_amem_q;

    logic            accept;
    t_comp           in_comp [DIMS];
    logic            vidx_ok, cidx_ok;
    logic [VA_W-1:0] mem_addr;
    logic [CA_W-1:0] cw_addr;
    t_lane_ctl       lane_ctl;
    logic            acc_match;
    logic            last_v_i, last_v_j, last_c_j, last_c_i, last_step;
    logic [9:0]      iter_next;
    logic            stop;
    logic            set_out;

    t_sq             lane_sq  [DIMS];
    t_comp           lane_new [DIMS];
    logic [DIMS-1:0] lane_bad;
    logic [DIMS-1:0] lane_used;
    logic [CA_W-1:0] pick;

    assign in_comp[0] = i_comp0;
    assign in_comp[1] = i_comp1;
    assign in_comp[2] = i_comp2;
    assign in_comp[3] = i_comp3;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign vidx_ok    = (32'(i_index) < MAX_VECTORS);
    assign cidx_ok    = (32'(i_index) < MAX_CODEWORDS);

    // clamped run settings
    always_comb begin
        if (r_cfg_nd == '0) begin
            n_nd = ND_W'(1);
        end else if (32'(r_cfg_nd) > DIMS) begin
            n_nd = ND_W'(DIMS);
        end else begin
            n_nd = ND_W'(r_cfg_nd);
        end
        if (r_cfg_nc == '0) begin
            n_nc = CC_W'(1);
        end else if (32'(r_cfg_nc) > MAX_CODEWORDS) begin
            n_nc = CC_W'(MAX_CODEWORDS);
        end else begin
            n_nc = CC_W'(r_cfg_nc);
        end
        if (r_cfg_nv == '0) begin
            n_nv = VC_W'(1);
        end else if (32'(r_cfg_nv) > MAX_VECTORS) begin
            n_nv = VC_W'(MAX_VECTORS);
        end else begin
            n_nv = VC_W'(r_cfg_nv);
        end
    end

    always_comb begin
        last_v_i  = (r_vi == r_nv - VC_W'(1));
        last_v_j  = (r_vj == r_nv - VC_W'(1));
        last_c_j  = (CC_W'(r_cj) == r_nc - CC_W'(1));
        last_c_i  = (CC_W'(r_ci) == r_nc - CC_W'(1));
        last_step = (r_dstep == DS_W'(ACC_W - 1));
        iter_next = r_iter + 10'd1;
        stop      = !r_bad || (iter_next >= r_cfg_maxit);
        acc_match = r_acc_pend && (r_amem_q == r_ci);
        for (int k = 0; k < DIMS; k++) begin
            lane_used[k] = (32'(r_nd) > k);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_operation == OP_RUN)) begin
                    n_state = ST_A_RD;
                end else if (accept && (i_operation == OP_READ_ASG)) begin
                    n_state = ST_RDASG;
                end
            end
            ST_RDASG:   n_state = ST_IDLE;
            ST_A_RD:    n_state = ST_A_ISSUE;
            ST_A_ISSUE: n_state = last_c_j ? ST_A_DRAIN : ST_A_ISSUE;
            ST_A_DRAIN: n_state = ST_A_WR;
            ST_A_WR:    n_state = last_v_i ? ST_U_SCAN : ST_A_RD;
            ST_U_SCAN:  n_state = last_v_j ? ST_U_DRAIN : ST_U_SCAN;
            ST_U_DRAIN: n_state = ST_U_LOAD;
            ST_U_LOAD:  n_state = ST_U_DIV;
            ST_U_DIV:   n_state = last_step ? ST_U_WB : ST_U_DIV;
            ST_U_WB:    n_state = last_c_i ? ST_ITER : ST_U_SCAN;
            ST_ITER:    n_state = stop ? ST_IDLE : ST_A_RD;
            default:    n_state = ST_IDLE;
        endcase
    end

    // decoded controls
    always_comb begin
        lane_ctl = '0;
        mem_addr = r_vi[VA_W-1:0];
        cw_addr  = r_ci;
        set_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                mem_addr = VA_W'(i_index);
                cw_addr  = CA_W'(i_index);
                set_out  = accept && (i_operation != OP_RUN)
                           && (i_operation != OP_READ_ASG);
            end
            ST_RDASG: set_out = 1'b1;
            ST_A_ISSUE: begin
                cw_addr        = r_cj;
                lane_ctl.sq_en = 1'b1;
            end
            ST_A_WR:    lane_ctl.acc_clr = last_v_i;
            ST_U_SCAN: begin
                mem_addr        = r_vj[VA_W-1:0];
                lane_ctl.acc_en = acc_match;
            end
            ST_U_DRAIN: lane_ctl.acc_en = acc_match;
            ST_U_LOAD:  lane_ctl.div_clr = 1'b1;
            ST_U_DIV:   lane_ctl.div_step = 1'b1;
            ST_U_WB:    lane_ctl.acc_clr = !last_c_i;
            ST_ITER:    set_out = stop;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_nd    <= 3'd2;
            r_cfg_nc    <= 5'd2;
            r_cfg_nv    <= 11'd10;
            r_cfg_maxit <= 10'd100;
            r_cfg_thr   <= 16'd1;
            r_iter      <= '0;
            r_conv      <= 1'b0;
            r_out_valid <= 1'b0;
            r_sq_pend   <= 1'b0;
            r_acc_pend  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sq_pend  <= (r_state == ST_A_ISSUE);
            r_acc_pend <= (r_state == ST_U_SCAN);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DIMS:   r_cfg_nd    <= i_cfg_data[2:0];
                    CFG_NCW:    r_cfg_nc    <= i_cfg_data[4:0];
                    CFG_NVEC:   r_cfg_nv    <= i_cfg_data[10:0];
                    CFG_MAXIT:  r_cfg_maxit <= i_cfg_data[9:0];
                    CFG_THRESH: r_cfg_thr   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && (i_operation == OP_RUN)) begin
                r_iter <= '0;
            end else if (r_state == ST_ITER) begin
                r_iter <= iter_next;
                if (stop) begin
                    r_conv <= !r_bad;
                end
            end
            if (set_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p1_j <= r_cj;
        unique case (r_state)
            ST_IDLE: begin
                r_rd_ok <= vidx_ok;
                r_nd    <= n_nd;
                r_nc    <= n_nc;
                r_nv    <= n_nv;
                r_vi    <= '0;
                r_bad   <= 1'b0;
                // hold the waiting result until the next transfer
                if (accept) begin
                    for (int k = 0; k < DIMS; k++) begin
                        r_out_comp[k] <= (i_operation == OP_READ_CW && cidx_ok)
                                         ? r_cb[cw_addr][k] : '0;
                    end
                    r_out_cluster <= '0;
                end
            end
            ST_RDASG: begin
                for (int k = 0; k < DIMS; k++) begin
                    r_out_comp[k] <= '0;
                end
                r_out_cluster <= r_rd_ok ? 4'(r_amem_q) : '0;
            end
            ST_A_RD:  r_cj <= '0;
            ST_A_ISSUE: r_cj <= r_cj + CA_W'(1);
            ST_A_WR: begin
                r_vi  <= r_vi + VC_W'(1);
                r_vj  <= '0;
                r_cnt <= '0;
                r_ci  <= '0;
            end
            ST_U_SCAN: begin
                r_vj <= r_vj + VC_W'(1);
                if (acc_match) begin
                    r_cnt <= r_cnt + VC_W'(1);
                end
            end
            ST_U_DRAIN: begin
                if (acc_match) begin
                    r_cnt <= r_cnt + VC_W'(1);
                end
            end
            ST_U_LOAD: r_dstep <= '0;
            ST_U_DIV:  r_dstep <= r_dstep + DS_W'(1);
            ST_U_WB: begin
                r_bad <= r_bad | (|lane_bad);
                r_ci  <= r_ci + CA_W'(1);
                r_vj  <= '0;
                r_cnt <= '0;
            end
            ST_ITER: begin
                r_vi  <= '0;
                r_bad <= 1'b0;
                for (int k = 0; k < DIMS; k++) begin
                    r_out_comp[k] <= '0;
                end
                r_out_cluster <= '0;
            end
            default: ;
        endcase
    end

    // vector and assignment stores
    always_ff @(posedge i_clk) begin
        if (accept && (i_operation == OP_LOAD_VEC) && vidx_ok) begin
            for (int k = 0; k < DIMS; k++) begin
                r_vmem[VA_W'(i_index)][k] <= in_comp[k];
            end
        end
        if (r_state == ST_A_WR) begin
            r_amem[r_vi[VA_W-1:0]] <= pick;
        end
        for (int k = 0; k < DIMS; k++) begin
            r_vmem_q[k] <= r_vmem[mem_addr][k];
        end
        r_amem_q <= r_amem[mem_addr];
    end

    // codebook
    always_ff @(posedge i_clk) begin
        if (accept && (i_operation == OP_LOAD_CW) && cidx_ok) begin
            for (int k = 0; k < DIMS; k++) begin
                r_cb[CA_W'(i_index)][k] <= in_comp[k];
            end
        end else if (r_state == ST_U_WB) begin
            for (int k = 0; k < DIMS; k++) begin
                if (lane_used[k]) begin
                    r_cb[r_ci][k] <= lane_new[k];
                end
            end
        end
    end

    for (genvar g = 0; g < DIMS; g++) begin : g_lane
        kct_lane #(
            .ACC_W (ACC_W),
            .VC_W  (VC_W)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_used (lane_used[g]),
            .i_vec  (r_vmem_q[g]),
            .i_cw   (r_cb[cw_addr][g]),
            .i_div  (r_cnt),
            .i_thr  (r_cfg_thr),
            .o_sq   (lane_sq[g]),
            .o_new  (lane_new[g]),
            .o_bad  (lane_bad[g])
        );
    end

    kct_merge #(
        .TAG_W (CA_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_A_RD),
        .i_valid (r_sq_pend),
        .i_tag   (r_p1_j),
        .i_sq    (lane_sq),
        .o_pick  (pick)
    );

    assign o_out_valid         = r_out_valid;
    assign o_out_comp0         = r_out_comp[0];
    assign o_out_comp1         = r_out_comp[1];
    assign o_out_comp2         = r_out_comp[2];
    assign o_out_comp3         = r_out_comp[3];
    assign o_cluster_of_vector = r_out_cluster;
    assign o_iterations_done   = r_iter;
    assign o_converged         = r_conv;

endmodule

### hw/rtl/kct_lane.sv
// ----------------------------------------------------------------------------
// kct_lane
// One component lane: squared difference for the nearest-codeword search,
// member sum for the mean, bit-serial divider and change check.
// ----------------------------------------------------------------------------
module kct_lane #(
    parameter int ACC_W = 26,
    parameter int VC_W  = 11
) (
    input  logic               i_clk,
    input  kct_pkg::t_lane_ctl i_ctl,
    input  logic               i_used,
    input  kct_pkg::t_comp     i_vec,
    input  kct_pkg::t_comp     i_cw,
    input  logic [VC_W-1:0]    i_div,
    input  kct_pkg::t_comp     i_thr,
    output kct_pkg::t_sq       o_sq,
    output kct_pkg::t_comp     o_new,
    output logic               o_bad
);
    import kct_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [VC_W-1:0]  r_rem;
    t_sq              r_sq;
    t_comp            diff;
    t_sq              sq;
    logic [VC_W:0]    tmp;
    logic             ge;
    logic [VC_W-1:0]  n_rem;
    t_comp            chg;

    always_comb begin
        diff  = (i_vec >= i_cw) ? (i_vec - i_cw) : (i_cw - i_vec);
        sq    = SQ_W'(diff) * SQ_W'(diff);
        tmp   = {r_rem, r_acc[ACC_W-1]};
        ge    = (tmp >= {1'b0, i_div});
        n_rem = ge ? VC_W'(tmp - {1'b0, i_div}) : VC_W'(tmp);
        o_new = (i_div == '0) ? i_cw : r_acc[COMP_BITS-1:0];
        chg   = (o_new >= i_cw) ? (o_new - i_cw) : (i_cw - o_new);
        o_bad = i_used && (chg >= i_thr);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sq_en) begin
            r_sq <= i_used ? sq : '0;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(i_vec);
        end else if (i_ctl.div_step) begin
            r_acc <= {r_acc[ACC_W-2:0], ge};
        end
        if (i_ctl.div_clr) begin
            r_rem <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= n_rem;
        end
    end

    assign o_sq = r_sq;

endmodule

### hw/rtl/kct_merge.sv
// ----------------------------------------------------------------------------
// kct_merge
// Sums the lane distances of one codeword and keeps the running nearest one;
// on equal distance the later codeword wins.
// ----------------------------------------------------------------------------
module kct_merge #(
    parameter int TAG_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_valid,
    input  logic [TAG_W-1:0] i_tag,
    input  kct_pkg::t_sq     i_sq [kct_pkg::DIMS],
    output logic [TAG_W-1:0] o_pick
);
    import kct_pkg::*;

    logic             r_have;
    logic [SUM_W-1:0] r_best;
    logic [TAG_W-1:0] r_pick;
    logic [SUM_W-1:0] sum;
    logic             take;

    always_comb begin
        sum = '0;
        for (int k = 0; k < DIMS; k++) begin
            sum = sum + SUM_W'(i_sq[k]);
        end
        take = i_valid && (!r_have || (sum <= r_best));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_start) begin
            r_have <= 1'b0;
        end else if (take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best <= sum;
            r_pick <= i_tag;
        end
    end

    assign o_pick = r_pick;

endmodule

### verif/kmeans_codebook_trainer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_codebook_trainer_tb
// Self-checking bench for the k-means codebook trainer. Loads vectors and
// codewords, runs training under many register settings and reads back
// codewords and assignments. Every result is checked against an in-bench
// model of the Lloyd iteration. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module kmeans_codebook_trainer_tb;
    import kct_pkg::*;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int         STALL_LIMIT    = 600000;

    typedef struct {
        logic [15:0] comp [4];
        logic [3:0]  cluster;
        logic [9:0]  iters;
        logic        conv;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_operation = '0;
    logic [9:0]  i_index = '0;
    logic [15:0] i_comp0 = '0;
    logic [15:0] i_comp1 = '0;
    logic [15:0] i_comp2 = '0;
    logic [15:0] i_comp3 = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_out_comp0;
    logic [15:0] o_out_comp1;
    logic [15:0] o_out_comp2;
    logic [15:0] o_out_comp3;
    logic [3:0]  o_cluster_of_vector;
    logic [9:0]  o_iterations_done;
    logic        o_converged;

    kmeans_codebook_trainer dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // model state
    logic [15:0] vec_mem [1024][4];
    logic [15:0] cw_mem  [16][4];
    logic [3:0]  asg_mem [1024];
    bit          vec_ok  [1024];
    bit          cw_ok   [16];
    bit          asg_ok  [1024];
    logic [9:0]  iter_cnt = '0;
    logic        conv_flag = 1'b0;
    logic [2:0]  r_dims = 3'd2;
    logic [4:0]  r_ncw = 5'd2;
    logic [10:0] r_nvec = 11'd10;
    logic [9:0]  r_maxit = 10'd100;
    logic [15:0] r_thresh = 16'd1;

    t_answer     pending [$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          stall_cnt = 0;

    function automatic int clamp(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_nd();  return clamp(r_dims, 4);    endfunction
    function automatic int eff_nc();  return clamp(r_ncw, 16);    endfunction
    function automatic int eff_nv();  return clamp(r_nvec, 1024); endfunction

    task automatic lloyd_train();
        int     nd, nc, nv, pick, cnt;
        bit     done;
        longint best, sqd, d, chg;
        longint sum [4];
        logic [15:0] nw;
        nd = eff_nd();
        nc = eff_nc();
        nv = eff_nv();
        iter_cnt = '0;
        do begin
            for (int i = 0; i < nv; i++) begin
                best = 64'h7fff_ffff_ffff_ffff;
                pick = 0;
                for (int j = 0; j < nc; j++) begin
                    sqd = 0;
                    for (int k = 0; k < nd; k++) begin
                        d = longint'(vec_mem[i][k]) - longint'(cw_mem[j][k]);
                        sqd += d * d;
                    end
                    if (sqd <= best) begin
                        best = sqd;
                        pick = j;
                    end
                end
                asg_mem[i] = pick[3:0];
                asg_ok[i] = 1'b1;
            end
            done = 1'b1;
            for (int j = 0; j < nc; j++) begin
                cnt = 0;
                for (int k = 0; k < 4; k++) sum[k] = 0;
                for (int i = 0; i < nv; i++) begin
                    if (asg_mem[i] == j) begin
                        cnt++;
                        for (int k = 0; k < nd; k++) sum[k] += vec_mem[i][k];
                    end
                end
                for (int k = 0; k < nd; k++) begin
                    nw = cw_mem[j][k];
                    if (cnt != 0) nw = 16'(sum[k] / cnt);
                    chg = (nw > cw_mem[j][k]) ? nw - cw_mem[j][k] : cw_mem[j][k] - nw;
                    cw_mem[j][k] = nw;
                    if (!(chg < r_thresh)) done = 1'b0;
                end
            end
            iter_cnt = iter_cnt + 10'd1;
        end while (!done && iter_cnt < r_maxit);
        conv_flag = done;
    endtask

    task automatic model_item(logic [2:0] op, logic [9:0] idx, logic [15:0] c [4]);
        t_answer a;
        for (int k = 0; k < 4; k++) a.comp[k] = '0;
        a.cluster = '0;
        case (op)
            OP_LOAD_VEC: begin
                for (int k = 0; k < 4; k++) vec_mem[idx][k] = c[k];
                vec_ok[idx] = 1'b1;
            end
            OP_LOAD_CW: begin
                if (idx < 16) begin
                    for (int k = 0; k < 4; k++) cw_mem[idx][k] = c[k];
                    cw_ok[idx] = 1'b1;
                end
            end
            OP_RUN: lloyd_train();
            OP_READ_CW: begin
                if (idx < 16) for (int k = 0; k < 4; k++) a.comp[k] = cw_mem[idx][k];
            end
            OP_READ_ASG: a.cluster = asg_mem[idx];
            default: ;
        endcase
        a.iters = iter_cnt;
        a.conv = conv_flag;
        pending.push_back(a);
    endtask

    // one transfer on the input channel; called just after a rising edge
    task automatic send_item(logic [2:0] op, logic [9:0] idx, logic [15:0] c [4]);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_index <= idx;
        i_comp0 <= c[0];
        i_comp1 <= c[1];
        i_comp2 <= c[2];
        i_comp3 <= c[3];
        do @(posedge i_clk); while (!o_in_ready);
        model_item(op, idx, c);
    endtask

    task automatic send_op(logic [2:0] op, logic [9:0] idx);
        logic [15:0] c [4];
        for (int k = 0; k < 4; k++) c[k] = 16'($urandom);
        send_item(op, idx, c);
    endtask

    task automatic send_fill(logic [2:0] op, logic [9:0] idx, logic [15:0] v);
        logic [15:0] c [4];
        for (int k = 0; k < 4; k++) c[k] = v;
        send_item(op, idx, c);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DIMS:   r_dims = val[2:0];
            CFG_NCW:    r_ncw = val[4:0];
            CFG_NVEC:   r_nvec = val[10:0];
            CFG_MAXIT:  r_maxit = val[9:0];
            CFG_THRESH: r_thresh = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(int dims, int ncw, int nvec, int maxit, int thresh);
        wait_idle();
        write_reg(CFG_DIMS, 16'(dims));
        write_reg(CFG_NCW, 16'(ncw));
        write_reg(CFG_NVEC, 16'(nvec));
        write_reg(CFG_MAXIT, 16'(maxit));
        write_reg(CFG_THRESH, 16'(thresh));
    endtask

    // fill whatever a run would read that is still unwritten
    task automatic load_missing();
        for (int i = 0; i < eff_nv(); i++) if (!vec_ok[i]) send_op(OP_LOAD_VEC, 10'(i));
        for (int j = 0; j < eff_nc(); j++) if (!cw_ok[j]) send_op(OP_LOAD_CW, 10'(j));
    endtask

    task automatic test_directed();
        set_regs(4, 2, 4, 100, 1);
        send_fill(OP_LOAD_VEC, 10'd0, 16'h0000);
        send_fill(OP_LOAD_VEC, 10'd1, 16'hffff);
        send_fill(OP_LOAD_VEC, 10'd2, 16'h8000);
        send_fill(OP_LOAD_VEC, 10'd3, 16'h7fff);
        // equal codewords: ties go to the later one, the other stays empty
        send_fill(OP_LOAD_CW, 10'd0, 16'h1234);
        send_fill(OP_LOAD_CW, 10'd1, 16'h1234);
        send_op(OP_LOAD_CW, 10'd1023);
        send_op(OP_READ_CW, 10'd20);
        send_op(OP_SPARE_FIRST, 10'd0);
        send_op(3'd6, 10'd1023);
        send_op(OP_SPARE_LAST, 10'd5);
        send_op(OP_RUN, 10'd0);
        send_op(OP_READ_CW, 10'd0);
        send_op(OP_READ_CW, 10'd1);
        for (int i = 0; i < 4; i++) send_op(OP_READ_ASG, 10'(i));
        send_fill(OP_LOAD_CW, 10'd0, 16'h0000);
        send_fill(OP_LOAD_CW, 10'd1, 16'hffff);
        send_op(OP_RUN, 10'd0);
        send_op(OP_READ_CW, 10'd0);
        send_op(OP_READ_CW, 10'd1);
        send_op(OP_READ_ASG, 10'd1);
    endtask

    task automatic test_reg_extremes();
        // out-of-range registers saturate; a zero limit still runs once
        set_regs(0, 0, 0, 0, 0);
        load_missing();
        send_op(OP_RUN, 10'd0);
        send_op(OP_READ_CW, 10'd0);
        // longest run on the smallest set, zero threshold never converges
        set_regs(1, 1, 1, 1023, 0);
        send_op(OP_RUN, 10'd0);
        send_op(OP_READ_ASG, 10'd0);
        // more codewords than vectors, loose threshold
        set_regs(7, 16, 3, 5, 65535);
        load_missing();
        send_op(OP_RUN, 10'd0);
        send_op(OP_READ_CW, 10'd15);
    endtask

    task automatic test_full_store();
        set_regs(7, 31, 2047, 2, 0);
        for (int i = 0; i < 1024; i++) send_op(OP_LOAD_VEC, 10'(i));
        for (int j = 0; j < 16; j++) send_op(OP_LOAD_CW, 10'(j));
        send_op(OP_RUN, 10'd0);
        send_op(OP_READ_ASG, 10'd1023);
        send_op(OP_READ_CW, 10'd7);
    endtask

    task automatic random_regs();
        int t;
        t = $urandom_range(9);
        set_regs($urandom_range(0, 7),
                 (t < 7) ? $urandom_range(0, 6) : $urandom_range(0, 31),
                 (t < 8) ? $urandom_range(0, 12) : $urandom_range(13, 2047) & 16'h0fff,
                 $urandom_range(0, 12),
                 (t < 3) ? 0 : (t < 7) ? $urandom_range(0, 400) :
                 (t == 7) ? 65535 : $urandom_range(0, 65535));
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        int r, nv;
        logic [9:0] idx;
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int n = 0; n < count; n++) begin
            if (n % 75 == 0) begin
                random_regs();
                if (eff_nv() > 40) set_regs(r_dims, r_ncw, $urandom_range(1, 40), r_maxit,
                                            r_thresh);
            end
            nv = eff_nv();
            r = $urandom_range(99);
            if (r < 35) begin
                idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, nv + 3));
                send_op(OP_LOAD_VEC, idx);
            end else if (r < 50) begin
                idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 17));
                send_op(OP_LOAD_CW, idx);
            end else if (r < 55) begin
                load_missing();
                send_op(OP_RUN, 10'($urandom));
            end else if (r < 72) begin
                idx = 10'($urandom);
                if (idx < 16 && !cw_ok[idx]) idx = 10'd16 + 10'($urandom_range(0, 1000));
                send_op(OP_READ_CW, idx);
            end else if (r < 94) begin
                idx = 10'($urandom_range(0, nv - 1));
                if (asg_ok[idx]) send_op(OP_READ_ASG, idx);
                else send_op(OP_SPARE_LAST, idx);
            end else begin
                send_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 10'($urandom));
            end
        end
    endtask

    // receiver with random stalls and the result checker
    always @(posedge i_clk) begin
        t_answer a;
        i_out_ready <= ($urandom_range(99) >= recv_idle);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                a = pending.pop_front();
                if (o_out_comp0 !== a.comp[0]) begin
                    $error("out_comp0 exp %h got %h", a.comp[0], o_out_comp0); errors++;
                end
                if (o_out_comp1 !== a.comp[1]) begin
                    $error("out_comp1 exp %h got %h", a.comp[1], o_out_comp1); errors++;
                end
                if (o_out_comp2 !== a.comp[2]) begin
                    $error("out_comp2 exp %h got %h", a.comp[2], o_out_comp2); errors++;
                end
                if (o_out_comp3 !== a.comp[3]) begin
                    $error("out_comp3 exp %h got %h", a.comp[3], o_out_comp3); errors++;
                end
                if (o_cluster_of_vector !== a.cluster) begin
                    $error("cluster_of_vector exp %0d got %0d", a.cluster,
                           o_cluster_of_vector);
                    errors++;
                end
                if (o_iterations_done !== a.iters) begin
                    $error("iterations_done exp %0d got %0d", a.iters, o_iterations_done);
                    errors++;
                end
                if (o_converged !== a.conv) begin
                    $error("converged exp %0d got %0d", a.conv, o_converged); errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_reg_extremes();
        test_full_store();
        test_random(100, 25, 86);
        test_random(100, 86, 25);
        test_random(100, 0, 0);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
